@@ sv/tapa_pkg.sv @@
`timescale 1ns / 1ps
// shared types, widths and register codes for the tensor axis permute address block
package tapa_pkg;

  localparam int AXES       = 4;
  localparam int AXIS_W     = 2;
  localparam int COUNT_W    = 3;
  localparam int SIZE_W     = 13;
  localparam int COORD_W    = 12;
  localparam int ORDER_W    = 8;
  localparam int ESIZE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int VALUE_W    = 64;
  localparam int DEST_W     = 48;
  localparam int SEQ_CNT_W  = 4;

  localparam int MAX_DIMS_DEF   = 4;
  localparam int INDEX_BITS_DEF = 48;

  localparam logic [SIZE_W-1:0]  SIZE_MAX    = 13'd4096;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 8'd228;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_ORDER  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE  = 3'd7;

  // element width codes
  localparam logic [ESIZE_W-1:0] ELEM_8  = 2'd0;
  localparam logic [ESIZE_W-1:0] ELEM_16 = 2'd1;
  localparam logic [ESIZE_W-1:0] ELEM_32 = 2'd2;
  localparam logic [ESIZE_W-1:0] ELEM_64 = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0]           dim_count;
    logic [AXES-1:0][SIZE_W-1:0]  dim_size;
    logic [ORDER_W-1:0]           dim_order;
    logic                         reverse_mode;
    logic [ESIZE_W-1:0]           element_size_code;
  } cfg_t;

  typedef struct packed {
    logic step;
    logic mac_clear;
    logic mac_en;
  } cell_ctl_t;

endpackage

@@ sv/tapa_cell.sv @@
`timescale 1ns / 1ps
// one odometer cell: a source coordinate and its share of the destination index
module tapa_cell #(
  parameter int INDEX_BITS = tapa_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tapa_pkg::cell_ctl_t           ctl,
  input  logic                          used,
  input  logic [tapa_pkg::SIZE_W-1:0]   src,
  input  logic [INDEX_BITS-1:0]         remap,
  input  logic                          carry_in,
  output logic                          carry_out,
  output logic [INDEX_BITS-1:0]         part
);

  logic [tapa_pkg::COORD_W-1:0] coord;
  logic [tapa_pkg::SIZE_W-1:0]  coord_inc;
  logic                         at_max;
  logic [INDEX_BITS-1:0]        mcand;
  logic [tapa_pkg::COORD_W-1:0] mplier;

  assign coord_inc = {1'b0, coord} + tapa_pkg::SIZE_W'(1);
  // unused axes never hold back the carry
  assign at_max    = !used || (coord_inc >= src);
  assign carry_out = carry_in && at_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord <= '0;
      part  <= '0;
    end else if (ctl.step) begin
      if (!used) begin
        coord <= '0;
        part  <= '0;
      end else if (carry_in) begin
        if (at_max) begin
          coord <= '0;
          part  <= '0;
        end else begin
          coord <= coord_inc[tapa_pkg::COORD_W-1:0];
          part  <= part + remap;
        end
      end
    end else if (ctl.mac_clear) begin
      part <= '0;
    end else if (ctl.mac_en) begin
      if (mplier[0]) begin
        part <= part + mcand;
      end
    end
  end

  // shift-add rebuild of part = coord * remap
  always_ff @(posedge clk) begin
    if (ctl.mac_clear) begin
      mcand  <= remap;
      mplier <= used ? coord : '0;
    end else if (ctl.mac_en) begin
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

@@ sv/tapa_geom.sv @@
`timescale 1ns / 1ps
// geometry sequencer: axis sizes, strides and cell rebuild after config changes
module tapa_geom #(
  parameter int MAX_DIMS   = tapa_pkg::MAX_DIMS_DEF,
  parameter int INDEX_BITS = tapa_pkg::INDEX_BITS_DEF,
  localparam int NCELL     = (MAX_DIMS < tapa_pkg::AXES) ? MAX_DIMS : tapa_pkg::AXES
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   restart,
  input  tapa_pkg::cfg_t                         cfg,
  output logic                                   busy,
  output tapa_pkg::cell_ctl_t                    seq,
  output logic [NCELL-1:0]                       used,
  output logic [NCELL-1:0][tapa_pkg::SIZE_W-1:0] src,
  output logic [NCELL-1:0][INDEX_BITS-1:0]       remap
);

  localparam int AX = tapa_pkg::AXES;
  localparam int AW = tapa_pkg::AXIS_W;
  localparam int CW = tapa_pkg::COUNT_W;
  localparam int SW = tapa_pkg::SIZE_W;
  localparam logic [CW-1:0] LIM = CW'(NCELL);

  localparam logic [1:0] G_DERIVE = 2'd0;
  localparam logic [1:0] G_MUL    = 2'd1;
  localparam logic [1:0] G_MAC    = 2'd2;
  localparam logic [1:0] G_READY  = 2'd3;

  logic [1:0]                     state;
  logic [tapa_pkg::SEQ_CNT_W-1:0] cnt;

  logic [CW-1:0]              d;
  logic [AX-1:0][SW-1:0]      sz;
  logic [AX-1:0][AW-1:0]      pa;
  logic [AX-1:0][AW-1:0]      pos;
  logic [AX-1:0]              seen;
  logic                       ok;
  logic [AX-1:0][SW-1:0]      src_c;
  logic [AX-1:0][AX-1:0]      mask_c;
  logic [AX-1:0]              used_c;

  logic [AX-1:0][SW-1:0]         src_r;
  logic [AX-1:0][AX-1:0]         mask_r;
  logic [AX-1:0]                 used_r;
  logic [AX-1:0][INDEX_BITS-1:0] remap_r;
  logic [AX-1:0][INDEX_BITS+SW-1:0] prod;

  // clamp shape, check order, find each source axis's place in the destination
  always_comb begin
    d = cfg.dim_count;
    if (d == '0) begin
      d = CW'(1);
    end else if (d > LIM) begin
      d = LIM;
    end
    ok   = 1'b1;
    seen = '0;
    for (int i = 0; i < AX; i++) begin
      if (cfg.dim_size[i] == '0) begin
        sz[i] = SW'(1);
      end else if (cfg.dim_size[i] > tapa_pkg::SIZE_MAX) begin
        sz[i] = tapa_pkg::SIZE_MAX;
      end else begin
        sz[i] = cfg.dim_size[i];
      end
      pa[i] = cfg.dim_order[AW*i +: AW];
      if (CW'(i) < d) begin
        if (({1'b0, pa[i]} >= d) || seen[pa[i]]) begin
          ok = 1'b0;
        end else begin
          seen[pa[i]] = 1'b1;
        end
      end
    end
    for (int i = 0; i < AX; i++) begin
      if (!ok || (CW'(i) >= d)) begin
        pa[i] = AW'(i);
      end
    end
    for (int a = 0; a < AX; a++) begin
      used_c[a] = CW'(a) < d;
      if (cfg.reverse_mode) begin
        pos[a]   = pa[a];
        src_c[a] = sz[pa[a]];
      end else begin
        pos[a]   = '0;
        src_c[a] = sz[a];
        for (int i = 0; i < AX; i++) begin
          if (pa[i] == AW'(a)) begin
            pos[a] = AW'(i);
          end
        end
      end
    end
    for (int a = 0; a < AX; a++) begin
      for (int b = 0; b < AX; b++) begin
        mask_c[a][b] = used_c[a] && used_c[b] && (pos[b] > pos[a]);
      end
    end
  end

  // one stride factor per cycle, all axes in parallel
  always_comb begin
    for (int a = 0; a < AX; a++) begin
      prod[a] = {{SW{1'b0}}, remap_r[a]} * {{INDEX_BITS{1'b0}}, src_r[cnt[AW-1:0]]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= G_DERIVE;
      cnt   <= '0;
    end else begin
      unique case (state)
        G_DERIVE: begin
          state <= G_MUL;
          cnt   <= '0;
        end
        G_MUL: begin
          if (cnt == tapa_pkg::SEQ_CNT_W'(AX - 1)) begin
            state <= G_MAC;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        G_MAC: begin
          if (cnt == tapa_pkg::SEQ_CNT_W'(tapa_pkg::COORD_W)) begin
            state <= G_READY;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        G_READY: begin
        end
        default: begin
          state <= G_DERIVE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == G_DERIVE) begin
      src_r  <= src_c;
      mask_r <= mask_c;
      used_r <= used_c;
      for (int a = 0; a < AX; a++) begin
        remap_r[a] <= INDEX_BITS'(1);
      end
    end else if (state == G_MUL) begin
      for (int a = 0; a < AX; a++) begin
        if (mask_r[a][cnt[AW-1:0]]) begin
          remap_r[a] <= prod[a][INDEX_BITS-1:0];
        end
      end
    end
  end

  assign busy          = state != G_READY;
  assign seq.step      = 1'b0;
  assign seq.mac_clear = (state == G_MAC) && (cnt == '0);
  assign seq.mac_en    = (state == G_MAC) && (cnt != '0);

  for (genvar a = 0; a < NCELL; a++) begin : g_out
    assign used[a]  = used_r[a];
    assign src[a]   = src_r[a];
    assign remap[a] = remap_r[a];
  end

endmodule

@@ sv/tensor_axis_permute_address.sv @@
`timescale 1ns / 1ps
// an accepted word passes the pair-sum register, then the output register
// throughput: one word per cycle unless stalled, set by each cell's single-add step
// reset: synchronous, active high; registers return to their reset values and the
//   geometry sequencer runs its steps (derive, 4 stride multiplies, 13 rebuild steps)
// any config write reruns those steps; in_ready stays low while they run
module tensor_axis_permute_address #(
  parameter int MAX_DIMS   = tapa_pkg::MAX_DIMS_DEF,
  parameter int INDEX_BITS = tapa_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tapa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tapa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tapa_pkg::VALUE_W-1:0]      element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tapa_pkg::DEST_W-1:0]       dest_index,
  output logic [tapa_pkg::VALUE_W-1:0]      out_value,
  output logic                              last_of_array
);

  localparam int NCELL = (MAX_DIMS < tapa_pkg::AXES) ? MAX_DIMS : tapa_pkg::AXES;
  localparam int VW    = tapa_pkg::VALUE_W;

  // config registers
  tapa_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_count         <= tapa_pkg::COUNT_W'(1);
      for (int i = 0; i < tapa_pkg::AXES; i++) begin
        cfg.dim_size[i] <= tapa_pkg::SIZE_W'(1);
      end
      cfg.dim_order         <= tapa_pkg::ORDER_RESET;
      cfg.reverse_mode      <= 1'b0;
      cfg.element_size_code <= tapa_pkg::ELEM_8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tapa_pkg::REG_DIM_COUNT:  cfg.dim_count <= cfg_data[tapa_pkg::COUNT_W-1:0];
        tapa_pkg::REG_DIM_SIZE_0: cfg.dim_size[0] <= cfg_data[tapa_pkg::SIZE_W-1:0];
        tapa_pkg::REG_DIM_SIZE_1: cfg.dim_size[1] <= cfg_data[tapa_pkg::SIZE_W-1:0];
        tapa_pkg::REG_DIM_SIZE_2: cfg.dim_size[2] <= cfg_data[tapa_pkg::SIZE_W-1:0];
        tapa_pkg::REG_DIM_SIZE_3: cfg.dim_size[3] <= cfg_data[tapa_pkg::SIZE_W-1:0];
        tapa_pkg::REG_DIM_ORDER:  cfg.dim_order <= cfg_data[tapa_pkg::ORDER_W-1:0];
        tapa_pkg::REG_REVERSE:    cfg.reverse_mode <= cfg_data[0];
        tapa_pkg::REG_ELEM_SIZE:  cfg.element_size_code <= cfg_data[tapa_pkg::ESIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // geometry: clamped sizes, used axes and destination stride per source axis
  logic                                   busy;
  tapa_pkg::cell_ctl_t                    seq;
  tapa_pkg::cell_ctl_t                    ctl;
  logic [NCELL-1:0]                       used;
  logic [NCELL-1:0][tapa_pkg::SIZE_W-1:0] src;
  logic [NCELL-1:0][INDEX_BITS-1:0]       remap;

  tapa_geom #(
    .MAX_DIMS   (MAX_DIMS),
    .INDEX_BITS (INDEX_BITS)
  ) u_geom (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .cfg     (cfg),
    .busy    (busy),
    .seq     (seq),
    .used    (used),
    .src     (src),
    .remap   (remap)
  );

  // pipeline handshake: each stage moves when the one after it is free or moving
  logic v1;
  logic v2;
  logic en1;
  logic en2;
  logic accept;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = !busy && !cfg_we && en1;
  assign accept   = in_valid && in_ready;

  assign ctl.step      = accept;
  assign ctl.mac_clear = seq.mac_clear;
  assign ctl.mac_en    = seq.mac_en;

  // odometer chain, innermost axis at the top end; carry[0] high means last word
  logic [NCELL:0]                   carry;
  logic [NCELL-1:0][INDEX_BITS-1:0] parts;

  assign carry[NCELL] = 1'b1;

  for (genvar a = 0; a < NCELL; a++) begin : g_cell
    tapa_cell #(
      .INDEX_BITS (INDEX_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .used      (used[a]),
      .src       (src[a]),
      .remap     (remap[a]),
      .carry_in  (carry[a+1]),
      .carry_out (carry[a]),
      .part      (parts[a])
    );
  end

  // pad the cell shares out to a fixed two-level adder tree
  logic [tapa_pkg::AXES-1:0][INDEX_BITS-1:0] part_pad;

  for (genvar k = 0; k < tapa_pkg::AXES; k++) begin : g_pad
    if (k < NCELL) begin : g_live
      assign part_pad[k] = parts[k];
    end else begin : g_zero
      assign part_pad[k] = '0;
    end
  end

  // element width mask
  logic [VW-1:0] masked;

  always_comb begin
    unique case (cfg.element_size_code)
      tapa_pkg::ELEM_8:  masked = {{(VW-8){1'b0}}, element_value[7:0]};
      tapa_pkg::ELEM_16: masked = {{(VW-16){1'b0}}, element_value[15:0]};
      tapa_pkg::ELEM_32: masked = {{(VW-32){1'b0}}, element_value[31:0]};
      tapa_pkg::ELEM_64: masked = element_value;
      default:           masked = element_value;
    endcase
  end

  // stage 1: pair sums; stage 2: output register
  logic [INDEX_BITS-1:0] sum_lo;
  logic [INDEX_BITS-1:0] sum_hi;
  logic                  last1;
  logic [VW-1:0]         val1;
  logic [INDEX_BITS-1:0] dest_full;
  logic                  last2;
  logic [VW-1:0]         val2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && accept) begin
      sum_lo <= part_pad[0] + part_pad[1];
      sum_hi <= part_pad[2] + part_pad[3];
      last1  <= carry[0];
      val1   <= masked;
    end
    if (en2 && v1) begin
      dest_full <= sum_lo + sum_hi;
      last2     <= last1;
      val2      <= val1;
    end
  end

  // fit the index to the 48-bit output word
  if (INDEX_BITS >= tapa_pkg::DEST_W) begin : g_dest_cut
    assign dest_index = dest_full[tapa_pkg::DEST_W-1:0];
  end else begin : g_dest_ext
    assign dest_index = {{(tapa_pkg::DEST_W-INDEX_BITS){1'b0}}, dest_full};
  end

  assign out_valid     = v2;
  assign out_value     = val2;
  assign last_of_array = last2;

endmodule

@@ sv/tapa_chk.sv @@
`timescale 1ns / 1ps
// port-level checker for the tensor axis permute address block, with its bind
module tapa_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_we,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [tapa_pkg::VALUE_W-1:0]      element_value,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tapa_pkg::DEST_W-1:0]       dest_index,
  input logic [tapa_pkg::VALUE_W-1:0]      out_value,
  input logic                              last_of_array
);

  // a waiting input word stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(element_value))
    else $error("input word withdrawn or changed while waiting");

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(dest_index) && $stable(out_value)
                                && $stable(last_of_array))
    else $error("output word changed while stalled");

  // geometry rebuild blocks input after reset
  a_reset_blocks: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken right after reset");

  // geometry rebuild blocks input after a register write
  a_cfg_blocks: assert property (@(posedge clk)
    cfg_we |=> !in_ready)
    else $error("input taken right after a config write");

endmodule

bind tensor_axis_permute_address tapa_chk u_chk (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for tensor_axis_permute_address with its own address predictor
module tb_top;
  import tapa_pkg::*;

  // generous bound: ~900 words each paying an idle gap and a stall burst,
  // ~35 register loads with their geometry rebuild, the long hold-off, reset clearing
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  // one output word as the block should present it
  typedef struct packed {
    logic [DEST_W-1:0]  dest_idx;
    logic [VALUE_W-1:0] elem;
    logic               last_flag;
  } dest_word_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = REG_DIM_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic [VALUE_W-1:0]    element_value = '0;
  logic                  out_ready     = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [DEST_W-1:0]     dest_index;
  logic [VALUE_W-1:0]    out_value;
  logic                  last_of_array;

  // predictor state: register copy and source coordinate odometer
  cfg_t                 model_cfg;
  logic [COORD_W-1:0]   src_coord [AXES];
  dest_word_t           dest_words_q [$];

  // shared knobs and bookkeeping
  int idle_pct      = 0;  // percent chance that a side starts an idle burst, per word sent or per receive cycle
  int hold_requests = 0;  // bumped by a test to ask the receiver for a long hold-off
  int items_sent    = 0;
  int words_checked = 0;
  int bad_words     = 0;
  int lasts_seen    = 0;
  int cfg_loads     = 0;
  int cycle_count   = 0;

  tensor_axis_permute_address u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .dest_index    (dest_index),
    .out_value     (out_value),
    .last_of_array (last_of_array)
  );

  always #5 clk = ~clk;

  // destination index, masked value and end flag for one source element,
  // then the odometer step; unused axes are held at zero
  function automatic dest_word_t permute_element(input logic [VALUE_W-1:0] v);
    int unsigned       d;
    logic [SIZE_W-1:0] sz [AXES];
    int unsigned       p [AXES];
    int unsigned       q [AXES];
    int unsigned       inv [AXES];
    logic [63:0]       src [AXES];
    logic [63:0]       nshape [AXES];
    logic [63:0]       nstride [AXES];
    logic [63:0]       remap [AXES];
    logic [63:0]       dest;
    logic [AXES-1:0]   seen;
    bit                ok;
    dest_word_t        w;
    // axis count clamps to 1..AXES
    d = 32'(model_cfg.dim_count);
    if (d < 1) d = 1;
    if (d > AXES) d = AXES;
    seen = '0;
    ok = 1'b1;
    // sizes clamp to 1..4096, order fields must form a permutation of the used axes
    for (int i = 0; i < d; i++) begin
      sz[i] = model_cfg.dim_size[i];
      if (sz[i] == '0) sz[i] = SIZE_W'(1);
      if (sz[i] > SIZE_MAX) sz[i] = SIZE_MAX;
      p[i] = 32'(model_cfg.dim_order[2*i +: AXIS_W]);
      if (p[i] >= d || seen[p[i]]) ok = 1'b0;
      else seen[p[i]] = 1'b1;
    end
    if (!ok) for (int i = 0; i < d; i++) p[i] = i;
    // reverse mode permutes the shape and walks the inverse order
    for (int i = 0; i < d; i++) begin
      if (model_cfg.reverse_mode) begin
        src[i]  = 64'(sz[p[i]]);
        q[p[i]] = i;
      end else begin
        src[i] = 64'(sz[i]);
        q[i]   = p[i];
      end
    end
    // row-major strides of the destination, mapped back onto source axes
    for (int i = 0; i < d; i++) nshape[i] = src[q[i]];
    nstride[d-1] = 64'd1;
    for (int i = d - 1; i > 0; i--) nstride[i-1] = nstride[i] * nshape[i];
    for (int i = 0; i < d; i++) inv[q[i]] = i;
    for (int i = 0; i < d; i++) remap[i] = nstride[inv[i]];
    for (int i = d; i < AXES; i++) src_coord[i] = '0;
    dest = '0;
    w.last_flag = 1'b1;
    for (int i = 0; i < d; i++) begin
      dest += 64'(src_coord[i]) * remap[i];
      if (64'(src_coord[i]) + 64'd1 < src[i]) w.last_flag = 1'b0;
    end
    w.dest_idx = dest[DEST_W-1:0];
    case (model_cfg.element_size_code)
      ELEM_8:  w.elem = {56'd0, v[7:0]};
      ELEM_16: w.elem = {48'd0, v[15:0]};
      ELEM_32: w.elem = {32'd0, v[31:0]};
      default: w.elem = v;
    endcase
    // odometer, last axis fastest; a counter at or past its end wraps and carries
    for (int s = d - 1; s >= 0; s--) begin
      if (64'(src_coord[s]) + 64'd1 < src[s]) begin
        src_coord[s] = src_coord[s] + COORD_W'(1);
        break;
      end
      src_coord[s] = '0;
    end
    return w;
  endfunction

  function automatic cfg_t make_cfg(input int cnt, input int s0, input int s1, input int s2,
                                    input int s3, input logic [ORDER_W-1:0] order,
                                    input logic rev, input logic [ESIZE_W-1:0] esize);
    cfg_t c;
    c.dim_count         = COUNT_W'(cnt);
    c.dim_size[0]       = SIZE_W'(s0);
    c.dim_size[1]       = SIZE_W'(s1);
    c.dim_size[2]       = SIZE_W'(s2);
    c.dim_size[3]       = SIZE_W'(s3);
    c.dim_order         = order;
    c.reverse_mode      = rev;
    c.element_size_code = esize;
    return c;
  endfunction

  // mostly small well-formed shapes with a valid axis order, now and then
  // out-of-range counts and sizes or a scrambled order
  function automatic cfg_t random_geometry();
    cfg_t        c;
    int unsigned dd;
    int unsigned lim;
    int          a [AXES];
    int          j;
    int          t;
    if ($urandom_range(99) < 85) c.dim_count = COUNT_W'($urandom_range(1, AXES));
    else c.dim_count = COUNT_W'($urandom_range(0, 7));
    dd = (c.dim_count == 0) ? 1 : ((c.dim_count > AXES) ? AXES : c.dim_count);
    lim = (dd <= 2) ? 8 : 3;
    for (int i = 0; i < AXES; i++) begin
      if ($urandom_range(99) < 6) begin
        case ($urandom_range(3))
          0:       c.dim_size[i] = '0;
          1:       c.dim_size[i] = SIZE_MAX;
          2:       c.dim_size[i] = SIZE_MAX + SIZE_W'(1);
          default: c.dim_size[i] = SIZE_W'($urandom_range(0, 8191));
        endcase
      end else begin
        c.dim_size[i] = SIZE_W'($urandom_range(1, lim));
      end
    end
    c.dim_order = ORDER_W'($urandom_range(0, 255));
    if ($urandom_range(99) < 80) begin
      for (int i = 0; i < AXES; i++) a[i] = i;
      for (int i = dd - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = a[i];
        a[i] = a[j];
        a[j] = t;
      end
      for (int i = 0; i < dd; i++) c.dim_order[2*i +: AXIS_W] = AXIS_W'(a[i]);
    end
    c.reverse_mode      = 1'($urandom_range(0, 1));
    c.element_size_code = ESIZE_W'($urandom_range(0, 3));
    return c;
  endfunction

  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one register write; the caller lowers cfg_we after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // load every register back to back; only called with nothing in flight
  task automatic program_cfg(input cfg_t c);
    write_reg(REG_DIM_COUNT,  CFG_DATA_W'(c.dim_count));
    write_reg(REG_DIM_SIZE_0, c.dim_size[0]);
    write_reg(REG_DIM_SIZE_1, c.dim_size[1]);
    write_reg(REG_DIM_SIZE_2, c.dim_size[2]);
    write_reg(REG_DIM_SIZE_3, c.dim_size[3]);
    write_reg(REG_DIM_ORDER,  CFG_DATA_W'(c.dim_order));
    write_reg(REG_REVERSE,    CFG_DATA_W'(c.reverse_mode));
    write_reg(REG_ELEM_SIZE,  CFG_DATA_W'(c.element_size_code));
    @(posedge clk);
    cfg_we <= 1'b0;
    // the counters stay as they are across a reload
    model_cfg = c;
    cfg_loads++;
  endtask

  // offer one element, maybe after an idle burst, and hold it until taken;
  // entered and left just after a rising edge
  task automatic offer_element(input logic [VALUE_W-1:0] v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (!in_ready);
    dest_words_q.insert(dest_words_q.size(), permute_element(v));
    items_sent++;
  endtask

  // drop valid and wait until every expected word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (dest_words_q.size() != 0);
  endtask

  // registers as they come out of reset: one axis of size one, every word ends the tensor
  task automatic test_reset_state();
    idle_pct = 0;
    offer_element('1);
    offer_element('0);
    wait_drained();
  endtask

  // 2x3x2 tensor with a rotated axis order, one full pass plus the wrap
  task automatic test_full_tensor();
    program_cfg(make_cfg(3, 2, 3, 2, 1, 8'h12, 1'b0, ELEM_16));
    repeat (13) offer_element(random_word());
    wait_drained();
  endtask

  // undo the same permutation, picking up mid-tensor with the counters kept
  task automatic test_reverse_midtensor();
    program_cfg(make_cfg(3, 2, 3, 2, 1, 8'h12, 1'b1, ELEM_32));
    offer_element(64'h8000_0000_0000_0001);
    offer_element(64'h0123_4567_89ab_cdef);
    offer_element(64'hfedc_ba98_7654_3210);
    offer_element(random_word());
    wait_drained();
  endtask

  // axis count above and below range, sizes of zero and past 4096, broken orders
  task automatic test_range_clamping();
    program_cfg(make_cfg(7, 0, 8191, 4097, 1, 8'hff, 1'b0, ELEM_64));
    offer_element('1);
    offer_element('0);
    offer_element(random_word());
    wait_drained();
    program_cfg(make_cfg(0, 4096, 1, 1, 1, 8'h1b, 1'b1, ELEM_8));
    offer_element(random_word());
    offer_element(random_word());
    wait_drained();
  endtask

  // full axis reversal on the largest shape, fastest axis lands on the top index bits
  task automatic test_wide_index();
    program_cfg(make_cfg(4, 4096, 4096, 4096, 4096, 8'h1b, 1'b0, ELEM_32));
    offer_element(random_word());
    offer_element(random_word());
    wait_drained();
  endtask

  // receiver holds off for a long stretch while words keep coming, so the block backs up
  task automatic test_backpressure();
    program_cfg(make_cfg(2, 3, 5, 1, 1, 8'h01, 1'b0, ELEM_16));
    idle_pct = 0;
    hold_requests++;
    repeat (40) offer_element(random_word());
    wait_drained();
  endtask

  // random register settings, each followed by a burst of words, with or without idling
  task automatic test_random_phases(input int n_items, input bit allow_idle);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      program_cfg(random_geometry());
      if (!allow_idle) idle_pct = 0;
      else case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      burst = $urandom_range(15, 50);
      repeat (burst) offer_element(random_word());
      sent += burst;
      wait_drained();
    end
  endtask

  // receiver: long hold-off on request, otherwise random stall bursts
  int hold_served = 0;
  int hold_left   = 0;
  int stall_left  = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left <= $urandom_range(1, 17) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare every accepted output word against the oldest prediction
  always @(posedge clk) begin
    dest_word_t want;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (last_of_array === 1'b1) lasts_seen++;
      if (dest_words_q.size() == 0) begin
        if (bad_words < 10)
          $display("unexpected word: dest_index %h out_value %h last %b",
                   dest_index, out_value, last_of_array);
        bad_words++;
      end else begin
        want = dest_words_q.pop_front();
        if (dest_index !== want.dest_idx || out_value !== want.elem ||
            last_of_array !== want.last_flag) begin
          if (bad_words < 10)
            $display("mismatch at word %0d: dest_index exp %h got %h, ",
                     words_checked, want.dest_idx, dest_index,
                     "out_value exp %h got %h, last exp %b got %b",
                     want.elem, out_value, want.last_flag, last_of_array);
          bad_words++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    model_cfg = make_cfg(1, 1, 1, 1, 1, ORDER_RESET, 1'b0, ELEM_8);
    for (int i = 0; i < AXES; i++) src_coord[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_full_tensor();
    test_reverse_midtensor();
    test_range_clamping();
    test_wide_index();
    test_backpressure();
    test_random_phases(640, 1'b1);
    // closing stretch runs flat out on both sides
    test_random_phases(140, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d elements over %0d register loads; %0d words checked, %0d tensor ends",
             items_sent, cfg_loads, words_checked, lasts_seen);
    $display("%0d mismatching or unexpected words", bad_words);
    if (bad_words == 0 && dest_words_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tapa_pkg.sv
sv/tapa_cell.sv
sv/tapa_geom.sv
sv/tensor_axis_permute_address.sv
sv/tapa_chk.sv
dv/tb_top.sv
